// ===== hdl/mesi_snoop_read_fifo_caches_top_macros.svh =====
// ============================================================================
// Assertion macros for the MESI snoop read path
// Macros for concurrent checks in the top-level RTL module.
// ============================================================================
`ifndef MESI_SNOOP_READ_FIFO_CACHES_TOP_MACROS_SVH
`define MESI_SNOOP_READ_FIFO_CACHES_TOP_MACROS_SVH

// Same-cycle implication under reset.
`define MSRF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("msrf check failed");

// Next-cycle implication under reset.
`define MSRF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("msrf check failed");

`endif

// ===== hdl/msrf_pkg.sv =====
// ============================================================================
// MESI snoop read path package
// Sizes, codes and shared types of the coherent cache read path.
// ============================================================================
package msrf_pkg;

    localparam int NUM_CPUS    = 3;
    localparam int LINES       = 8;
    localparam int MEM_WORDS   = 64;
    localparam int DATA_BITS   = 16;
    localparam int CPU_BITS    = 2;
    localparam int LINE_BITS   = $clog2(LINES);
    localparam int ADDR_BITS   = $clog2(MEM_WORDS);
    localparam int BLK_BITS    = ADDR_BITS - 1;
    localparam int BLOCKS      = MEM_WORDS / 2;
    localparam int TOTAL_LINES = NUM_CPUS * LINES;
    localparam int LIDX_BITS   = $clog2(TOTAL_LINES);

    typedef enum logic [1:0] {
        MESI_I = 2'd0,
        MESI_S = 2'd1,
        MESI_E = 2'd2,
        MESI_M = 2'd3
    } t_mesi;

    typedef enum logic [1:0] {
        SRC_OWN  = 2'd0,
        SRC_MEM  = 2'd1,
        SRC_PEER = 2'd2,
        SRC_NONE = 2'd3
    } t_src;

    typedef enum logic {
        OP_READ    = 1'b0,
        OP_PRELOAD = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_WRITE
    } t_fsm;

    typedef struct packed {
        logic                   own_hit;
        logic [LINE_BITS-1:0]   own_line;
        t_mesi                  own_state;
        logic                   peer_hit;
        logic [CPU_BITS-1:0]    peer_cpu;
        logic [LINE_BITS-1:0]   peer_line;
        logic [TOTAL_LINES-1:0] peer_match;
        logic [LINE_BITS-1:0]   victim;
    } t_lookup;

    typedef struct packed {
        logic                   fill_en;
        logic [CPU_BITS-1:0]    fill_cpu;
        logic [LINE_BITS-1:0]   fill_line;
        logic [BLK_BITS-1:0]    fill_blk;
        t_mesi                  fill_state;
        logic [TOTAL_LINES-1:0] share_vec;
    } t_update;

    function automatic logic [LIDX_BITS-1:0] line_idx(input logic [CPU_BITS-1:0] cpu,
                                                      input logic [LINE_BITS-1:0] line);
        line_idx = LIDX_BITS'(int'(cpu) * LINES + int'(line));
    endfunction

endpackage

// ===== hdl/msrf_tag_dir.sv =====
// ============================================================================
// Tag directory
// Tags, MESI states and FIFO fill pointers of all caches, with parallel snoop.
// ============================================================================
module msrf_tag_dir (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [msrf_pkg::CPU_BITS-1:0]    i_cpu,
    input  logic [msrf_pkg::BLK_BITS-1:0]    i_blk,
    input  msrf_pkg::t_update                i_upd,
    output msrf_pkg::t_lookup                o_look
);

    logic                           r_valid [msrf_pkg::TOTAL_LINES];
    logic [msrf_pkg::BLK_BITS-1:0]  r_blk   [msrf_pkg::TOTAL_LINES];
    msrf_pkg::t_mesi                r_mesi  [msrf_pkg::TOTAL_LINES];
    logic [msrf_pkg::LINE_BITS-1:0] r_ptr   [msrf_pkg::NUM_CPUS];

    logic [msrf_pkg::TOTAL_LINES-1:0] match;
    logic [msrf_pkg::CPU_BITS-1:0]    cpu_safe;

    always_comb begin
        for (int j = 0; j < msrf_pkg::TOTAL_LINES; j++) begin
            match[j] = r_valid[j] && (r_blk[j] == i_blk) && (r_mesi[j] != msrf_pkg::MESI_I);
        end
    end

    assign cpu_safe = (int'(i_cpu) < msrf_pkg::NUM_CPUS) ? i_cpu : '0;

    always_comb begin
        o_look = '0;
        for (int l = msrf_pkg::LINES - 1; l >= 0; l--) begin
            if (match[int'(cpu_safe) * msrf_pkg::LINES + l]) begin
                o_look.own_hit   = 1'b1;
                o_look.own_line  = msrf_pkg::LINE_BITS'(l);
                o_look.own_state = r_mesi[int'(cpu_safe) * msrf_pkg::LINES + l];
            end
        end
        for (int p = msrf_pkg::NUM_CPUS - 1; p >= 0; p--) begin
            if (p != int'(i_cpu)) begin
                for (int l = msrf_pkg::LINES - 1; l >= 0; l--) begin
                    if (match[p * msrf_pkg::LINES + l]) begin
                        o_look.peer_hit  = 1'b1;
                        o_look.peer_cpu  = msrf_pkg::CPU_BITS'(p);
                        o_look.peer_line = msrf_pkg::LINE_BITS'(l);
                        o_look.peer_match[p * msrf_pkg::LINES + l] = 1'b1;
                    end
                end
            end
        end
        o_look.victim = r_ptr[cpu_safe];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < msrf_pkg::TOTAL_LINES; j++) begin
                r_valid[j] <= 1'b0;
                r_mesi[j]  <= msrf_pkg::MESI_I;
            end
            for (int p = 0; p < msrf_pkg::NUM_CPUS; p++) begin
                r_ptr[p] <= '0;
            end
        end else begin
            for (int j = 0; j < msrf_pkg::TOTAL_LINES; j++) begin
                if (i_upd.share_vec[j]) begin
                    r_mesi[j] <= msrf_pkg::MESI_S;
                end
            end
            if (i_upd.fill_en) begin
                r_valid[msrf_pkg::line_idx(i_upd.fill_cpu, i_upd.fill_line)] <= 1'b1;
                r_mesi[msrf_pkg::line_idx(i_upd.fill_cpu, i_upd.fill_line)]  <= i_upd.fill_state;
                r_ptr[i_upd.fill_cpu] <= (int'(i_upd.fill_line) == msrf_pkg::LINES - 1)
                                         ? '0 : i_upd.fill_line + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd.fill_en) begin
            r_blk[msrf_pkg::line_idx(i_upd.fill_cpu, i_upd.fill_line)] <= i_upd.fill_blk;
        end
    end

endmodule

// ===== hdl/mesi_snoop_read_fifo_caches_top.sv =====
// ============================================================================
// MESI snoop read path, top level
// Coherent read path of several small caches over a shared block memory.
// ============================================================================
// Requests arrive as beats on the input channel (i_in_valid / o_in_ready).
// A read beat produces one result beat on the output channel; a preload beat
// or a read from a nonexistent processor produces none.
// A read passes through the snoop state, where the parallel tag snoop also
// launches the line and memory reads, and then the write state, which writes
// back the line, tags and FIFO pointer. A new beat is taken in the write
// state but not in the snoop state; a preload writes memory in the snoop
// state and then returns to idle. The result sits in an output register.
// When the receiver stalls, the block holds the finished read in the write
// state until the register frees up. Reset empties all caches and makes
// shared memory read as zero, with no clearing pass.
// ============================================================================
`include "mesi_snoop_read_fifo_caches_top_macros.svh"

module mesi_snoop_read_fifo_caches_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_op,
    input  logic [msrf_pkg::CPU_BITS-1:0]    i_cpu_id,
    input  logic [msrf_pkg::ADDR_BITS-1:0]   i_address,
    input  logic [msrf_pkg::DATA_BITS-1:0]   i_write_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_hit,
    output logic [1:0]                       o_source,
    output logic [msrf_pkg::CPU_BITS-1:0]    o_supplier_cpu,
    output logic [msrf_pkg::LINE_BITS-1:0]   o_line_index,
    output logic [msrf_pkg::DATA_BITS-1:0]   o_read_data,
    output logic [1:0]                       o_line_state
);

    localparam int DW = msrf_pkg::DATA_BITS;

    msrf_pkg::t_fsm r_state, n_state;

    logic                            r_op;
    logic [msrf_pkg::CPU_BITS-1:0]   r_cpu;
    logic [msrf_pkg::ADDR_BITS-1:0]  r_addr;
    logic [DW-1:0]                   r_wdata;
    msrf_pkg::t_lookup               look, r_look;
    msrf_pkg::t_update               upd;

    logic [2*DW-1:0]                 line_mem [msrf_pkg::TOTAL_LINES];
    logic [DW-1:0]                   mem_even [msrf_pkg::BLOCKS];
    logic [DW-1:0]                   mem_odd  [msrf_pkg::BLOCKS];
    logic [msrf_pkg::MEM_WORDS-1:0]  r_mem_vld;
    logic [2*DW-1:0]                 r_line_rd;
    logic [DW-1:0]                   r_even_rd, r_odd_rd;
    logic                            r_even_vld, r_odd_vld;

    logic                            r_out_valid, r_hit;
    logic [1:0]                      r_source, r_line_state;
    logic [msrf_pkg::CPU_BITS-1:0]   r_supplier;
    logic [msrf_pkg::LINE_BITS-1:0]  r_line_index;
    logic [DW-1:0]                   r_read_data;

    logic                            accept, slot_free, read_ok, finish, preload_wr;
    logic [msrf_pkg::BLK_BITS-1:0]   blk;
    logic [msrf_pkg::LIDX_BITS-1:0]  rd_idx;
    logic [2*DW-1:0]                 fill;
    logic [DW-1:0]                   word;

    assign blk       = r_addr[msrf_pkg::ADDR_BITS-1:1];
    assign slot_free = !r_out_valid || i_out_ready;
    assign read_ok   = (r_op == msrf_pkg::OP_READ) && (int'(r_cpu) < msrf_pkg::NUM_CPUS);
    assign accept    = i_in_valid && o_in_ready;

    msrf_tag_dir u_tag_dir (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cpu   (r_cpu),
        .i_blk   (blk),
        .i_upd   (upd),
        .o_look  (look)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            msrf_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = msrf_pkg::ST_LOOK;
                end
            end
            msrf_pkg::ST_LOOK: begin
                n_state = read_ok ? msrf_pkg::ST_WRITE : msrf_pkg::ST_IDLE;
            end
            msrf_pkg::ST_WRITE: begin
                if (slot_free) begin
                    n_state = i_in_valid ? msrf_pkg::ST_LOOK : msrf_pkg::ST_IDLE;
                end
            end
            default: n_state = msrf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        finish     = 1'b0;
        preload_wr = 1'b0;
        unique case (r_state)
            msrf_pkg::ST_IDLE:  o_in_ready = 1'b1;
            msrf_pkg::ST_LOOK:  preload_wr = (r_op == msrf_pkg::OP_PRELOAD);
            msrf_pkg::ST_WRITE: begin
                o_in_ready = slot_free;
                finish     = slot_free;
            end
            default: o_in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= msrf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_op;
            r_cpu   <= i_cpu_id;
            r_addr  <= i_address;
            r_wdata <= i_write_data;
        end
        if (r_state == msrf_pkg::ST_LOOK) begin
            r_look <= look;
        end
    end

    assign rd_idx = look.own_hit ? msrf_pkg::line_idx(r_cpu, look.own_line)
                                 : msrf_pkg::line_idx(look.peer_cpu, look.peer_line);

    always_ff @(posedge i_clk) begin
        r_line_rd <= line_mem[rd_idx];
        r_even_rd <= mem_even[blk];
        r_odd_rd  <= mem_odd[blk];
        if (preload_wr) begin
            if (r_addr[0]) begin
                mem_odd[blk] <= r_wdata;
            end else begin
                mem_even[blk] <= r_wdata;
            end
        end
        if (upd.fill_en) begin
            line_mem[msrf_pkg::line_idx(upd.fill_cpu, upd.fill_line)] <= fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_vld <= '0;
        end else if (preload_wr) begin
            r_mem_vld[r_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_even_vld <= r_mem_vld[{blk, 1'b0}];
        r_odd_vld  <= r_mem_vld[{blk, 1'b1}];
    end

    always_comb begin
        if (r_look.peer_hit) begin
            fill = r_line_rd;
        end else begin
            fill = {r_odd_vld ? r_odd_rd : '0, r_even_vld ? r_even_rd : '0};
        end
    end

    always_comb begin
        upd            = '0;
        upd.fill_en    = finish && !r_look.own_hit;
        upd.fill_cpu   = r_cpu;
        upd.fill_line  = r_look.victim;
        upd.fill_blk   = blk;
        upd.fill_state = r_look.peer_hit ? msrf_pkg::MESI_S : msrf_pkg::MESI_E;
        upd.share_vec  = (finish && !r_look.own_hit) ? r_look.peer_match : '0;
    end

    always_comb begin
        logic [2*DW-1:0] src_word;
        src_word = r_look.own_hit ? r_line_rd : fill;
        word     = r_addr[0] ? src_word[2*DW-1:DW] : src_word[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_hit       <= r_look.own_hit;
            r_read_data <= word;
            if (r_look.own_hit) begin
                r_source     <= msrf_pkg::SRC_OWN;
                r_supplier   <= '0;
                r_line_index <= r_look.own_line;
                r_line_state <= r_look.own_state;
            end else begin
                r_source     <= r_look.peer_hit ? msrf_pkg::SRC_PEER : msrf_pkg::SRC_MEM;
                r_supplier   <= r_look.peer_hit ? r_look.peer_cpu : '0;
                r_line_index <= r_look.victim;
                r_line_state <= r_look.peer_hit ? msrf_pkg::MESI_S : msrf_pkg::MESI_E;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_hit          = r_hit;
    assign o_source       = r_source;
    assign o_supplier_cpu = r_supplier;
    assign o_line_index   = r_line_index;
    assign o_read_data    = r_read_data;
    assign o_line_state   = r_line_state;

    `MSRF_ASSERT_IMP(a_accept_state, accept,
        (r_state == msrf_pkg::ST_IDLE) || (r_state == msrf_pkg::ST_WRITE))
    `MSRF_ASSERT_IMP(a_own_is_hit, o_out_valid && (o_source == msrf_pkg::SRC_OWN), o_hit)
    `MSRF_ASSERT_IMP(a_mem_fill_excl, o_out_valid && (o_source == msrf_pkg::SRC_MEM),
        o_line_state == msrf_pkg::MESI_E)
    `MSRF_ASSERT_NXT(a_finish_shows, finish, o_out_valid)

endmodule

// ===== verif/testbench.sv =====
// ============================================================================
// MESI snoop read path testbench
// Drives read and preload beats with random idling on both channels and
// compares every result beat against a cycle-free coherence predictor.
// ============================================================================
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                           op;
        logic [msrf_pkg::CPU_BITS-1:0]  cpu;
        logic [msrf_pkg::ADDR_BITS-1:0] addr;
        logic [msrf_pkg::DATA_BITS-1:0] wdata;
    } t_req;

    typedef struct packed {
        logic                           hit;
        logic [1:0]                     src;
        logic [msrf_pkg::CPU_BITS-1:0]  sup;
        logic [msrf_pkg::LINE_BITS-1:0] line;
        logic [msrf_pkg::DATA_BITS-1:0] data;
        logic [1:0]                     state;
    } t_resp;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic i_op = 1'b0;
    logic [msrf_pkg::CPU_BITS-1:0] i_cpu_id = '0;
    logic [msrf_pkg::ADDR_BITS-1:0] i_address = '0;
    logic [msrf_pkg::DATA_BITS-1:0] i_write_data = '0;
    logic i_out_ready = 1'b0;
    logic o_in_ready, o_out_valid, o_hit;
    logic [1:0] o_source, o_line_state;
    logic [msrf_pkg::CPU_BITS-1:0] o_supplier_cpu;
    logic [msrf_pkg::LINE_BITS-1:0] o_line_index;
    logic [msrf_pkg::DATA_BITS-1:0] o_read_data;

    mesi_snoop_read_fifo_caches_top u_top (.*);

    always #5 i_clk = ~i_clk;

    // Predictor state.
    logic                           pv_valid [msrf_pkg::NUM_CPUS][msrf_pkg::LINES];
    logic [msrf_pkg::BLK_BITS-1:0]  pv_blk   [msrf_pkg::NUM_CPUS][msrf_pkg::LINES];
    msrf_pkg::t_mesi                pv_state [msrf_pkg::NUM_CPUS][msrf_pkg::LINES];
    logic [msrf_pkg::DATA_BITS-1:0] pv_words [msrf_pkg::NUM_CPUS][msrf_pkg::LINES][2];
    logic [msrf_pkg::DATA_BITS-1:0] pv_mem   [msrf_pkg::MEM_WORDS];
    logic [msrf_pkg::LINE_BITS-1:0] pv_fifo  [msrf_pkg::NUM_CPUS][msrf_pkg::LINES];
    int                             pv_fills [msrf_pkg::NUM_CPUS];

    t_req  pending_reqs[$];
    t_resp expected_reads[$];
    int    errors = 0;
    bit    stim_done = 0;
    bit    calm = 0;
    int    in_gap = 0, out_gap = 0, idle_cycles = 0;

    function automatic int lookup_line(int c, logic [msrf_pkg::BLK_BITS-1:0] b);
        for (int i = 0; i < msrf_pkg::LINES; i++)
            if (pv_valid[c][i] && pv_blk[c][i] == b && pv_state[c][i] != msrf_pkg::MESI_I)
                return i;
        return -1;
    endfunction

    function automatic int pick_fill_line(int c);
        int v;
        if (pv_fills[c] < msrf_pkg::LINES) begin
            for (int i = 0; i < msrf_pkg::LINES; i++)
                if (!pv_valid[c][i]) begin
                    pv_fifo[c][pv_fills[c]] = msrf_pkg::LINE_BITS'(i);
                    pv_fills[c]++;
                    return i;
                end
            return 0;
        end
        v = pv_fifo[c][0];
        for (int i = 1; i < msrf_pkg::LINES; i++) pv_fifo[c][i-1] = pv_fifo[c][i];
        pv_fifo[c][msrf_pkg::LINES-1] = msrf_pkg::LINE_BITS'(v);
        return v;
    endfunction

    task automatic predict_access(input t_req r);
        logic [msrf_pkg::BLK_BITS-1:0] b;
        int off, c, fl, sl, ln, pl;
        t_resp e;
        logic [msrf_pkg::DATA_BITS-1:0] fw [2];
        b = r.addr[msrf_pkg::ADDR_BITS-1:1];
        off = r.addr[0];
        c = r.cpu;
        sl = -1;
        e = '0;
        if (r.op == msrf_pkg::OP_PRELOAD) begin
            pv_mem[r.addr] = r.wdata;
            return;
        end
        if (c >= msrf_pkg::NUM_CPUS) return;
        fl = lookup_line(c, b);
        if (fl >= 0) begin
            e.hit = 1'b1;
            e.src = msrf_pkg::SRC_OWN;
            e.line = msrf_pkg::LINE_BITS'(fl);
            e.data = pv_words[c][fl][off];
            e.state = pv_state[c][fl];
            expected_reads.push_back(e);
            return;
        end
        for (int p = 0; p < msrf_pkg::NUM_CPUS; p++) begin
            if (p == c) continue;
            pl = lookup_line(p, b);
            if (pl < 0) continue;
            if (pv_state[p][pl] == msrf_pkg::MESI_M)
                for (int k = 0; k < 2; k++) pv_mem[{b, k[0]}] = pv_words[p][pl][k];
            if (sl < 0) begin
                sl = pl;
                e.sup = msrf_pkg::CPU_BITS'(p);
                fw[0] = pv_words[p][pl][0];
                fw[1] = pv_words[p][pl][1];
            end
            pv_state[p][pl] = msrf_pkg::MESI_S;
        end
        if (sl < 0) begin
            fw[0] = pv_mem[{b, 1'b0}];
            fw[1] = pv_mem[{b, 1'b1}];
            e.src = msrf_pkg::SRC_MEM;
            e.state = msrf_pkg::MESI_E;
        end else begin
            e.src = msrf_pkg::SRC_PEER;
            e.state = msrf_pkg::MESI_S;
        end
        ln = pick_fill_line(c);
        pv_valid[c][ln] = 1'b1;
        pv_blk[c][ln] = b;
        pv_state[c][ln] = msrf_pkg::t_mesi'(e.state);
        pv_words[c][ln][0] = fw[0];
        pv_words[c][ln][1] = fw[1];
        e.line = msrf_pkg::LINE_BITS'(ln);
        e.data = fw[off];
        expected_reads.push_back(e);
    endtask

    function automatic t_req make_req(logic op, int cpu, int addr,
                                      logic [msrf_pkg::DATA_BITS-1:0] d);
        t_req r;
        r.op = op;
        r.cpu = msrf_pkg::CPU_BITS'(cpu);
        r.addr = msrf_pkg::ADDR_BITS'(addr);
        r.wdata = d;
        return r;
    endfunction

    // Driver.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                predict_access({i_op, i_cpu_id, i_address, i_write_data});
            end
            if (!i_in_valid || o_in_ready) begin
                if (in_gap > 0) begin
                    in_gap <= in_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_reqs.size() > 0 && !calm && $urandom_range(0, 5) == 0) begin
                    in_gap <= $urandom_range(0, 2);
                    i_in_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    t_req r;
                    r = pending_reqs.pop_front();
                    i_in_valid <= 1'b1;
                    i_op <= r.op;
                    i_cpu_id <= r.cpu;
                    i_address <= r.addr;
                    i_write_data <= r.wdata;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                i_out_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                out_gap <= $urandom_range(0, 2);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 2000) begin
                $display("Regression FAIL");
                $finish;
            end
            if (o_out_valid && i_out_ready) begin
                t_resp a, e;
                a = {o_hit, o_source, o_supplier_cpu, o_line_index, o_read_data, o_line_state};
                if (expected_reads.size() == 0) begin
                    errors <= errors + 1;
                    if (errors < 10) $display("Unexpected result beat: exp none, act %h", a);
                end else begin
                    e = expected_reads.pop_front();
                    if (a !== e) begin
                        errors <= errors + 1;
                        if (errors < 10) begin
                            $display("Mismatch: exp hit=%0d src=%0d sup=%0d line=%0d data=%h st=%0d",
                                e.hit, e.src, e.sup, e.line, e.data, e.state);
                            $display("          act hit=%0d src=%0d sup=%0d line=%0d data=%h st=%0d",
                                a.hit, a.src, a.sup, a.line, a.data, a.state);
                        end
                    end
                end
            end
        end
    end

    initial begin
        for (int c = 0; c < msrf_pkg::NUM_CPUS; c++) begin
            pv_fills[c] = 0;
            for (int l = 0; l < msrf_pkg::LINES; l++) begin
                pv_valid[c][l] = 1'b0;
                pv_blk[c][l] = '0;
                pv_state[c][l] = msrf_pkg::MESI_I;
                pv_fifo[c][l] = '0;
                pv_words[c][l][0] = '0;
                pv_words[c][l][1] = '0;
            end
        end
        for (int m = 0; m < msrf_pkg::MEM_WORDS; m++) pv_mem[m] = '0;

        // Directed: preloads at extremes, memory fill, own hit, peer share,
        // ignored processor, FIFO replacement after a cache fills.
        pending_reqs.push_back(make_req(msrf_pkg::OP_PRELOAD, 3, 0, 16'hFFFF));
        pending_reqs.push_back(make_req(msrf_pkg::OP_PRELOAD, 0, 63, 16'h0000));
        pending_reqs.push_back(make_req(msrf_pkg::OP_PRELOAD, 2, 62, 16'hA5A5));
        pending_reqs.push_back(make_req(msrf_pkg::OP_READ, 0, 0, 16'hFFFF));
        pending_reqs.push_back(make_req(msrf_pkg::OP_READ, 0, 1, 0));
        pending_reqs.push_back(make_req(msrf_pkg::OP_READ, 1, 0, 0));
        pending_reqs.push_back(make_req(msrf_pkg::OP_READ, 2, 63, 0));
        pending_reqs.push_back(make_req(msrf_pkg::OP_READ, 1, 62, 0));
        pending_reqs.push_back(make_req(msrf_pkg::OP_READ, 3, 5, 0));
        pending_reqs.push_back(make_req(msrf_pkg::OP_PRELOAD, 1, 0, 16'h1234));
        pending_reqs.push_back(make_req(msrf_pkg::OP_READ, 0, 0, 0));
        for (int i = 0; i < 10; i++)
            pending_reqs.push_back(make_req(msrf_pkg::OP_READ, 2, 2 * i + 10, 0));
        pending_reqs.push_back(make_req(msrf_pkg::OP_READ, 2, 10, 0));

        for (int i = 0; i < 1500; i++) begin
            if ($urandom_range(0, 3) == 0)
                pending_reqs.push_back(make_req(msrf_pkg::OP_PRELOAD, $urandom_range(0, 3),
                    $urandom_range(0, 63), msrf_pkg::DATA_BITS'($urandom)));
            else
                pending_reqs.push_back(make_req(msrf_pkg::OP_READ,
                    ($urandom_range(0, 15) == 0) ? 3 : $urandom_range(0, 2),
                    ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 63),
                    msrf_pkg::DATA_BITS'($urandom)));
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_reqs.size() <= 200);
        calm = 1;
        wait (pending_reqs.size() == 0);
        @(posedge i_clk);
        while (i_in_valid) @(posedge i_clk);
        while (expected_reads.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0 && expected_reads.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/msrf_pkg.sv
hdl/msrf_tag_dir.sv
hdl/mesi_snoop_read_fifo_caches_top.sv
verif/testbench.sv
